// ===== src/tadst_pkg.sv =====
// Shared types, register indexes and reset values for the two-axis deadband speed tracker.
package tadst_pkg;

    // Coordinate width default
    localparam int COORD_BITS_DEF = 12;

    // Configuration port widths
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_GAIN       = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_SPEED  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_SPEED  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_DEADBAND   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_HYSTERESIS = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT    = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_ACCEL      = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_INVERT     = 3'd7;

    // Reset values
    localparam logic [15:0] RST_GAIN       = 16'd1280;  // 5.0 in Q8.8
    localparam logic [15:0] RST_MAX_SPEED  = 16'd500;
    localparam logic [15:0] RST_MIN_SPEED  = 16'd20;
    localparam logic [11:0] RST_DEADBAND   = 12'd3;
    localparam logic [11:0] RST_HYSTERESIS = 12'd2;
    localparam logic [31:0] RST_TIMEOUT    = 32'd100;
    localparam logic [7:0]  RST_ACCEL      = 8'd100;
    localparam logic [1:0]  RST_INVERT     = 2'd0;

    // Live configuration seen by the datapath
    typedef struct packed {
        logic [15:0] gain_q8_8;
        logic [15:0] max_speed;
        logic [15:0] min_speed;
        logic [11:0] deadband;
        logic [11:0] hysteresis;
        logic [31:0] timeout_ms;
        logic [7:0]  accel_code;
        logic [1:0]  invert_mask;
    } t_cfg;

    // Per-axis command
    typedef struct packed {
        logic        direction;
        logic [15:0] speed;
        logic        stopped;
    } t_axis_cmd;

endpackage

// ===== src/tadst_cfg_regs.sv =====
// Configuration register file for the tracker.
module tadst_cfg_regs (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [tadst_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [tadst_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    output tadst_pkg::t_cfg                    o_cfg
);
    import tadst_pkg::*;

    t_cfg r_cfg;

    // Writes are always taken
    assign o_cfg_ready = 1'b1;
    assign o_cfg       = r_cfg;

    // Register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.gain_q8_8   <= RST_GAIN;
            r_cfg.max_speed   <= RST_MAX_SPEED;
            r_cfg.min_speed   <= RST_MIN_SPEED;
            r_cfg.deadband    <= RST_DEADBAND;
            r_cfg.hysteresis  <= RST_HYSTERESIS;
            r_cfg.timeout_ms  <= RST_TIMEOUT;
            r_cfg.accel_code  <= RST_ACCEL;
            r_cfg.invert_mask <= RST_INVERT;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_GAIN:       r_cfg.gain_q8_8   <= i_cfg_data[15:0];
                REG_MAX_SPEED:  r_cfg.max_speed   <= i_cfg_data[15:0];
                REG_MIN_SPEED:  r_cfg.min_speed   <= i_cfg_data[15:0];
                REG_DEADBAND:   r_cfg.deadband    <= i_cfg_data[11:0];
                REG_HYSTERESIS: r_cfg.hysteresis  <= i_cfg_data[11:0];
                REG_TIMEOUT:    r_cfg.timeout_ms  <= i_cfg_data;
                REG_ACCEL:      r_cfg.accel_code  <= i_cfg_data[7:0];
                REG_INVERT:     r_cfg.invert_mask <= i_cfg_data[1:0];
                default: begin
                end
            endcase
        end
    end

endmodule

// ===== src/tadst_axis.sv =====
// One axis: error, hysteresis deadband, proportional speed with clamps, direction.
module tadst_axis #(
    parameter int COORD_BITS = tadst_pkg::COORD_BITS_DEF
) (
    input  logic [COORD_BITS-1:0]  i_target,
    input  logic [COORD_BITS-1:0]  i_laser,
    input  logic                   i_stopped,
    input  logic                   i_invert,
    input  tadst_pkg::t_cfg        i_cfg,
    output tadst_pkg::t_axis_cmd   o_cmd
);
    import tadst_pkg::*;

    localparam int ERR_W  = COORD_BITS + 1;
    localparam int THR_W  = 13;
    localparam int CMP_W  = (COORD_BITS > THR_W) ? COORD_BITS : THR_W;
    localparam int PROD_W = 16 + COORD_BITS;
    localparam int SPD_W  = PROD_W - 8;

    logic signed [ERR_W-1:0]  err;
    logic [ERR_W-1:0]         err_neg;
    logic [COORD_BITS-1:0]    mag;
    logic [THR_W-1:0]         thr;
    logic                     in_band;
    logic [PROD_W-1:0]        prod;
    logic [SPD_W-1:0]         spd_full;
    logic [15:0]              spd_sat;
    logic                     err_pos;

    // Signed error and its magnitude
    assign err     = $signed({1'b0, i_target}) - $signed({1'b0, i_laser});
    assign err_neg = -err;
    assign mag     = err[ERR_W-1] ? err_neg[COORD_BITS-1:0] : err[COORD_BITS-1:0];
    assign err_pos = !err[ERR_W-1] && (err != '0);

    // Deadband, widened while the axis is stopped
    assign thr     = i_stopped ? ({1'b0, i_cfg.deadband} + {1'b0, i_cfg.hysteresis})
                               : {1'b0, i_cfg.deadband};
    assign in_band = CMP_W'(mag) <= CMP_W'(thr);

    // Q8.8 gain times magnitude, truncated, clamped to max
    assign prod     = PROD_W'(i_cfg.gain_q8_8) * PROD_W'(mag);
    assign spd_full = prod[PROD_W-1:8];
    assign spd_sat  = (spd_full > SPD_W'(i_cfg.max_speed)) ? i_cfg.max_speed
                                                           : spd_full[15:0];

    // Command selection
    always_comb begin
        o_cmd.direction = 1'b0;
        o_cmd.speed     = '0;
        o_cmd.stopped   = 1'b1;
        if (!in_band && !(spd_sat < i_cfg.min_speed)) begin
            o_cmd.direction = err_pos ^ i_invert;
            o_cmd.speed     = spd_sat;
            o_cmd.stopped   = 1'b0;
        end
    end

endmodule

// ===== src/two_axis_deadband_speed_tracker_top.sv =====
// Top level of the two-axis deadband speed tracker.
//
// Takes one tracking request per clock while the output is not stalled and returns
// at most one motor command per request, held first in the input register, then in
// the result register. Each request reads and writes the heartbeat and stopped bits
// in the cycle it leaves the input register. A request can be accepted while a
// finished command waits on a stalled output. Configuration writes are always ready
// and apply to requests computed afterward.
module two_axis_deadband_speed_tracker_top #(
    parameter int COORD_BITS = tadst_pkg::COORD_BITS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // configuration
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [tadst_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [tadst_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    // request channel
    input  logic                              i_valid,
    output logic                              o_stall,
    input  logic [31:0]                       i_now_ms,
    input  logic                              i_laser_fresh,
    input  logic                              i_target_fresh,
    input  logic                              i_both_valid,
    input  logic [COORD_BITS-1:0]             i_target_px_x,
    input  logic [COORD_BITS-1:0]             i_target_px_y,
    input  logic [COORD_BITS-1:0]             i_laser_px_x,
    input  logic [COORD_BITS-1:0]             i_laser_px_y,
    input  logic                              i_stop_request,
    // command channel
    output logic                              o_valid,
    input  logic                              i_stall,
    output logic                              o_x_direction,
    output logic [15:0]                       o_x_speed,
    output logic                              o_y_direction,
    output logic [15:0]                       o_y_speed,
    output logic [7:0]                        o_motor_accel,
    output logic                              o_flags_consumed,
    output logic                              o_timed_out
);
    import tadst_pkg::*;

    t_cfg                  cfg;
    t_axis_cmd             x_cmd;
    t_axis_cmd             y_cmd;

    // input register
    logic                  r_in_valid;
    logic [31:0]           r_now_ms;
    logic                  r_laser_fresh;
    logic                  r_target_fresh;
    logic                  r_both_valid;
    logic [COORD_BITS-1:0] r_target_px_x;
    logic [COORD_BITS-1:0] r_target_px_y;
    logic [COORD_BITS-1:0] r_laser_px_x;
    logic [COORD_BITS-1:0] r_laser_px_y;
    logic                  r_stop_request;

    // tracker state
    logic [31:0]           r_heartbeat_ms;
    logic [1:0]            r_stopped;

    // result register
    logic                  r_out_valid;

    logic                  advance;
    logic                  in_take;
    logic [31:0]           n_heartbeat_ms;
    logic [31:0]           elapsed;
    logic                  timeout;
    logic                  track;

    tadst_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    tadst_axis #(.COORD_BITS(COORD_BITS)) u_axis_x (
        .i_target  (r_target_px_x),
        .i_laser   (r_laser_px_x),
        .i_stopped (r_stopped[0]),
        .i_invert  (cfg.invert_mask[0]),
        .i_cfg     (cfg),
        .o_cmd     (x_cmd)
    );

    tadst_axis #(.COORD_BITS(COORD_BITS)) u_axis_y (
        .i_target  (r_target_px_y),
        .i_laser   (r_laser_px_y),
        .i_stopped (r_stopped[1]),
        .i_invert  (cfg.invert_mask[1]),
        .i_cfg     (cfg),
        .o_cmd     (y_cmd)
    );

    // Handshake: the held request moves on when the result register is empty or its command is taken
    assign advance = r_in_valid && (!r_out_valid || !i_stall);
    assign o_stall = r_in_valid && !advance;
    assign in_take = i_valid && !o_stall;

    // Heartbeat refresh and wrapping timeout
    assign n_heartbeat_ms = r_laser_fresh ? r_now_ms : r_heartbeat_ms;
    assign elapsed        = r_now_ms - n_heartbeat_ms;
    assign timeout        = elapsed > cfg.timeout_ms;
    assign track          = r_both_valid && (r_laser_fresh || r_target_fresh);

    assign o_valid = r_out_valid;

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_take) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
        if (in_take) begin
            r_now_ms       <= i_now_ms;
            r_laser_fresh  <= i_laser_fresh;
            r_target_fresh <= i_target_fresh;
            r_both_valid   <= i_both_valid;
            r_target_px_x  <= i_target_px_x;
            r_target_px_y  <= i_target_px_y;
            r_laser_px_x   <= i_laser_px_x;
            r_laser_px_y   <= i_laser_px_y;
            r_stop_request <= i_stop_request;
        end
    end

    // State update and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_heartbeat_ms <= '0;
            r_stopped      <= 2'b11;
            r_out_valid    <= 1'b0;
        end else if (advance) begin
            o_motor_accel <= cfg.accel_code;
            if (r_stop_request) begin
                r_stopped        <= 2'b11;
                r_out_valid      <= 1'b1;
                o_x_direction    <= 1'b0;
                o_x_speed        <= '0;
                o_y_direction    <= 1'b0;
                o_y_speed        <= '0;
                o_flags_consumed <= 1'b0;
                o_timed_out      <= 1'b0;
            end else begin
                r_heartbeat_ms <= n_heartbeat_ms;
                if (timeout) begin
                    r_stopped        <= 2'b11;
                    r_out_valid      <= 1'b1;
                    o_x_direction    <= 1'b0;
                    o_x_speed        <= '0;
                    o_y_direction    <= 1'b0;
                    o_y_speed        <= '0;
                    o_flags_consumed <= 1'b0;
                    o_timed_out      <= 1'b1;
                end else if (track) begin
                    r_stopped        <= {y_cmd.stopped, x_cmd.stopped};
                    r_out_valid      <= 1'b1;
                    o_x_direction    <= x_cmd.direction;
                    o_x_speed        <= x_cmd.speed;
                    o_y_direction    <= y_cmd.direction;
                    o_y_speed        <= y_cmd.speed;
                    o_flags_consumed <= 1'b1;
                    o_timed_out      <= 1'b0;
                end else begin
                    // nothing to send; a previous command leaves at this edge
                    r_out_valid <= 1'b0;
                end
            end
        end else if (r_out_valid && !i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

endmodule

// ===== test/tb_two_axis_deadband_speed_tracker_top.sv =====
// Self-checking testbench for the two-axis deadband speed tracker top level.
`timescale 1ns / 1ps

module tb_two_axis_deadband_speed_tracker_top;
    import tadst_pkg::*;

    // One tracking request as presented on the input ports
    typedef struct packed {
        logic [31:0] now_ms;
        logic        laser_fresh;
        logic        target_fresh;
        logic        both_valid;
        logic [11:0] target_px_x;
        logic [11:0] target_px_y;
        logic [11:0] laser_px_x;
        logic [11:0] laser_px_y;
        logic        stop_request;
    } t_track_req;

    // One motor command as seen on the output ports
    typedef struct packed {
        logic        x_direction;
        logic [15:0] x_speed;
        logic        y_direction;
        logic [15:0] y_speed;
        logic [7:0]  motor_accel;
        logic        flags_consumed;
        logic        timed_out;
    } t_motor_cmd;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  i_cfg_valid;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;
    logic                  i_valid;
    logic                  o_stall;
    logic [31:0]           i_now_ms;
    logic                  i_laser_fresh;
    logic                  i_target_fresh;
    logic                  i_both_valid;
    logic [11:0]           i_target_px_x;
    logic [11:0]           i_target_px_y;
    logic [11:0]           i_laser_px_x;
    logic [11:0]           i_laser_px_y;
    logic                  i_stop_request;
    logic                  o_valid;
    logic                  i_stall = 1'b0;
    logic                  o_x_direction;
    logic [15:0]           o_x_speed;
    logic                  o_y_direction;
    logic [15:0]           o_y_speed;
    logic [7:0]            o_motor_accel;
    logic                  o_flags_consumed;
    logic                  o_timed_out;

    // Predictor state: live registers, heartbeat and per-axis stopped bits
    t_cfg        shadow_cfg;
    logic [31:0] heartbeat;
    logic [1:0]  axis_stopped;

    t_motor_cmd  expected_cmds[$];
    int          error_count = 0;
    int          tx_idle_pct = 13;
    int          rx_idle_pct = 13;
    int          hold_requests = 0;
    logic [31:0] wall_ms = 32'd0;

    localparam int RX_HOLD_CYCLES = 60;

    always #5 i_clk = ~i_clk;

    two_axis_deadband_speed_tracker_top u_dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_valid      (i_cfg_valid),
        .o_cfg_ready      (o_cfg_ready),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .i_valid          (i_valid),
        .o_stall          (o_stall),
        .i_now_ms         (i_now_ms),
        .i_laser_fresh    (i_laser_fresh),
        .i_target_fresh   (i_target_fresh),
        .i_both_valid     (i_both_valid),
        .i_target_px_x    (i_target_px_x),
        .i_target_px_y    (i_target_px_y),
        .i_laser_px_x     (i_laser_px_x),
        .i_laser_px_y     (i_laser_px_y),
        .i_stop_request   (i_stop_request),
        .o_valid          (o_valid),
        .i_stall          (i_stall),
        .o_x_direction    (o_x_direction),
        .o_x_speed        (o_x_speed),
        .o_y_direction    (o_y_direction),
        .o_y_speed        (o_y_speed),
        .o_motor_accel    (o_motor_accel),
        .o_flags_consumed (o_flags_consumed),
        .o_timed_out      (o_timed_out)
    );

    // One axis: deadband with hysteresis, Q8.8 gain, clamp, min-speed cutoff
    function automatic void predict_axis(input logic [11:0] tgt, input logic [11:0] spot,
                                         input int axis, output logic dir,
                                         output logic [15:0] spd);
        logic signed [13:0] err;
        logic [11:0]        mag;
        logic [12:0]        thr;
        logic [27:0]        prod;
        logic [19:0]        rate;
        err = $signed({2'b00, tgt}) - $signed({2'b00, spot});
        mag = (err < 0) ? 12'(-err) : 12'(err);
        thr = axis_stopped[axis] ? {1'b0, shadow_cfg.deadband} + {1'b0, shadow_cfg.hysteresis}
                                 : {1'b0, shadow_cfg.deadband};
        dir = 1'b0;
        spd = 16'd0;
        if (mag <= thr) begin
            axis_stopped[axis] = 1'b1;
            return;
        end
        prod = 28'(shadow_cfg.gain_q8_8) * 28'(mag);
        rate = prod[27:8];
        if (rate > 20'(shadow_cfg.max_speed))
            rate = 20'(shadow_cfg.max_speed);
        if (rate < 20'(shadow_cfg.min_speed)) begin
            axis_stopped[axis] = 1'b1;
            return;
        end
        dir = (err > 0) ^ shadow_cfg.invert_mask[axis];
        spd = rate[15:0];
        axis_stopped[axis] = 1'b0;
    endfunction

    // Motor command caused by one request; returns 0 when nothing is sent
    function automatic logic predict_motor_cmd(input t_track_req r, output t_motor_cmd c);
        logic [31:0] age;
        c = '0;
        c.motor_accel = shadow_cfg.accel_code;
        if (r.stop_request) begin
            axis_stopped = 2'b11;
            return 1'b1;
        end
        if (r.laser_fresh)
            heartbeat = r.now_ms;
        age = r.now_ms - heartbeat;
        if (age > shadow_cfg.timeout_ms) begin
            axis_stopped = 2'b11;
            c.timed_out = 1'b1;
            return 1'b1;
        end
        if (!r.both_valid || (!r.laser_fresh && !r.target_fresh))
            return 1'b0;
        predict_axis(r.target_px_x, r.laser_px_x, 0, c.x_direction, c.x_speed);
        predict_axis(r.target_px_y, r.laser_px_y, 1, c.y_direction, c.y_speed);
        c.flags_consumed = 1'b1;
        return 1'b1;
    endfunction

    task automatic report_mismatch(input string msg);
        error_count++;
        if (error_count <= 50)
            $display("MISMATCH @%0t: %s", $time, msg);
    endtask

    // Offer one request at the falling edge, hold it until accepted
    task automatic send_request(input t_track_req r);
        t_motor_cmd cmd;
        @(negedge i_clk);
        while ($urandom_range(0, 99) < tx_idle_pct) begin
            i_valid = 1'b0;
            @(negedge i_clk);
        end
        i_valid        = 1'b1;
        i_now_ms       = r.now_ms;
        i_laser_fresh  = r.laser_fresh;
        i_target_fresh = r.target_fresh;
        i_both_valid   = r.both_valid;
        i_target_px_x  = r.target_px_x;
        i_target_px_y  = r.target_px_y;
        i_laser_px_x   = r.laser_px_x;
        i_laser_px_y   = r.laser_px_y;
        i_stop_request = r.stop_request;
        do @(posedge i_clk); while (o_stall);
        if (predict_motor_cmd(r, cmd))
            expected_cmds.push_back(cmd);
    endtask

    task automatic send_track(input logic [31:0] now, input logic lf, input logic tf,
                              input logic bv, input logic [11:0] tx, input logic [11:0] ty,
                              input logic [11:0] lx, input logic [11:0] ly);
        t_track_req r;
        r = '{now, lf, tf, bv, tx, ty, lx, ly, 1'b0};
        send_request(r);
    endtask

    // Stop offering and wait until every command is back and the pipe is empty
    task automatic drain_commands();
        @(negedge i_clk);
        i_valid = 1'b0;
        while (expected_cmds.size() != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // Write all eight registers while idle; upper data bits carry junk
    task automatic apply_config(input t_cfg c);
        logic [CFG_IDX_W-1:0]  idx;
        logic [CFG_DATA_W-1:0] data;
        drain_commands();
        for (int k = 0; k < 8; k++) begin
            idx  = CFG_IDX_W'(k);
            data = $urandom;
            case (idx)
                REG_GAIN:       data[15:0] = c.gain_q8_8;
                REG_MAX_SPEED:  data[15:0] = c.max_speed;
                REG_MIN_SPEED:  data[15:0] = c.min_speed;
                REG_DEADBAND:   data[11:0] = c.deadband;
                REG_HYSTERESIS: data[11:0] = c.hysteresis;
                REG_TIMEOUT:    data       = c.timeout_ms;
                REG_ACCEL:      data[7:0]  = c.accel_code;
                REG_INVERT:     data[1:0]  = c.invert_mask;
                default:        data       = '0;
            endcase
            @(negedge i_clk);
            i_cfg_valid = 1'b1;
            i_cfg_index = idx;
            i_cfg_data  = data;
            do @(posedge i_clk); while (!o_cfg_ready);
        end
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
        shadow_cfg = c;
    endtask

    function automatic t_cfg random_config();
        t_cfg c;
        c.gain_q8_8   = ($urandom_range(0, 99) < 20) ? 16'($urandom) : 16'($urandom_range(0, 2048));
        c.max_speed   = ($urandom_range(0, 99) < 20) ? 16'($urandom) : 16'($urandom_range(0, 2000));
        c.min_speed   = ($urandom_range(0, 99) < 10) ? 16'($urandom) : 16'($urandom_range(0, 50));
        c.deadband    = ($urandom_range(0, 99) < 10) ? 12'($urandom) : 12'($urandom_range(0, 15));
        c.hysteresis  = ($urandom_range(0, 99) < 10) ? 12'($urandom) : 12'($urandom_range(0, 15));
        case ($urandom_range(0, 3))
            0:       c.timeout_ms = 32'd0;
            1:       c.timeout_ms = $urandom_range(1, 200);
            2:       c.timeout_ms = $urandom;
            default: c.timeout_ms = 32'hFFFF_FFFF;
        endcase
        c.accel_code  = 8'($urandom);
        c.invert_mask = 2'($urandom);
        return c;
    endfunction

    // Mostly well-formed tracking calls near the thresholds, some stops and noise
    task automatic gen_tracking_req(output t_track_req r);
        int unsigned pick;
        int unsigned span;
        int          off;
        pick = $urandom_range(0, 99);
        r.now_ms       = $urandom;
        r.laser_fresh  = 1'($urandom_range(0, 1));
        r.target_fresh = 1'($urandom_range(0, 1));
        r.both_valid   = 1'($urandom_range(0, 1));
        r.target_px_x  = 12'($urandom_range(0, 4095));
        r.target_px_y  = 12'($urandom_range(0, 4095));
        r.laser_px_x   = 12'($urandom_range(0, 4095));
        r.laser_px_y   = 12'($urandom_range(0, 4095));
        r.stop_request = (pick < 5);
        if (pick >= 12) begin
            if ($urandom_range(0, 99) < 3)
                wall_ms += shadow_cfg.timeout_ms + $urandom_range(1, 20);
            else
                wall_ms += $urandom_range(0, 40);
            r.now_ms       = wall_ms;
            r.laser_fresh  = ($urandom_range(0, 99) < 85);
            r.target_fresh = ($urandom_range(0, 99) < 80);
            r.both_valid   = ($urandom_range(0, 99) < 95);
            span = shadow_cfg.deadband + shadow_cfg.hysteresis + 4;
            if ($urandom_range(0, 99) >= 25) begin
                off = int'($urandom_range(0, 2 * span)) - int'(span);
                r.target_px_x = 12'(r.laser_px_x + off);
            end
            if ($urandom_range(0, 99) >= 25) begin
                off = int'($urandom_range(0, 2 * span)) - int'(span);
                r.target_px_y = 12'(r.laser_px_y + off);
            end
        end
    endtask

    // Receiver: random stalls, plus long hold-offs counted here
    always @(negedge i_clk) begin : rx_stall_gen
        int hold_left;
        int hold_served;
        if (hold_requests != hold_served) begin
            hold_served = hold_requests;
            hold_left   = RX_HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_stall = 1'b1;
        end else begin
            i_stall = ($urandom_range(0, 99) < rx_idle_pct);
        end
    end

    // Compare every accepted command with the oldest expectation
    always @(posedge i_clk) begin : cmd_check
        t_motor_cmd got;
        t_motor_cmd want;
        if (i_rst_n && o_valid && !i_stall) begin
            got = '{o_x_direction, o_x_speed, o_y_direction, o_y_speed,
                    o_motor_accel, o_flags_consumed, o_timed_out};
            if (expected_cmds.size() == 0) begin
                report_mismatch("command with no request pending");
            end else begin
                want = expected_cmds.pop_front();
                if (got.x_direction !== want.x_direction)
                    report_mismatch($sformatf("x_direction got %0b exp %0b",
                                              got.x_direction, want.x_direction));
                if (got.x_speed !== want.x_speed)
                    report_mismatch($sformatf("x_speed got %0d exp %0d",
                                              got.x_speed, want.x_speed));
                if (got.y_direction !== want.y_direction)
                    report_mismatch($sformatf("y_direction got %0b exp %0b",
                                              got.y_direction, want.y_direction));
                if (got.y_speed !== want.y_speed)
                    report_mismatch($sformatf("y_speed got %0d exp %0d",
                                              got.y_speed, want.y_speed));
                if (got.motor_accel !== want.motor_accel)
                    report_mismatch($sformatf("motor_accel got %0d exp %0d",
                                              got.motor_accel, want.motor_accel));
                if (got.flags_consumed !== want.flags_consumed)
                    report_mismatch($sformatf("flags_consumed got %0b exp %0b",
                                              got.flags_consumed, want.flags_consumed));
                if (got.timed_out !== want.timed_out)
                    report_mismatch($sformatf("timed_out got %0b exp %0b",
                                              got.timed_out, want.timed_out));
            end
        end
    end

    // Reset values: stop, nothing-to-do, hysteresis, timeout and time wrap
    task automatic test_directed_defaults();
        t_track_req r;
        r = '{32'hFFFF_FFFF, 1'b1, 1'b1, 1'b1, 12'hFFF, 12'hFFF, 12'h000, 12'h000, 1'b1};
        send_request(r);
        send_track(32'd10, 1'b1, 1'b1, 1'b0, 12'd50, 12'd50, 12'd0, 12'd0);    // not both seen
        send_track(32'd20, 1'b0, 1'b0, 1'b1, 12'd50, 12'd50, 12'd0, 12'd0);    // no fresh data
        send_track(32'd30, 1'b1, 1'b1, 1'b1, 12'd4095, 12'd0, 12'd0, 12'd4095); // full-scale
        send_track(32'd31, 1'b1, 1'b1, 1'b1, 12'd100, 12'd100, 12'd97, 12'd104); // x in band
        send_track(32'd32, 1'b1, 1'b0, 1'b1, 12'd105, 12'd100, 12'd100, 12'd103); // hysteresis
        send_track(32'd33, 1'b0, 1'b1, 1'b1, 12'd106, 12'd106, 12'd100, 12'd100); // restart
        send_track(32'd140, 1'b0, 1'b1, 1'b1, 12'd200, 12'd200, 12'd100, 12'd100); // silent
        send_track(32'd141, 1'b1, 1'b1, 1'b1, 12'd7, 12'd7, 12'd7, 12'd7);     // zero error
        send_track(32'hFFFF_FFF0, 1'b1, 1'b1, 1'b1, 12'd0, 12'd20, 12'd30, 12'd0);
        send_track(32'h0000_0050, 1'b0, 1'b1, 1'b1, 12'd40, 12'd9, 12'd0, 12'd0); // age 96
        send_track(32'h0000_0055, 1'b0, 1'b1, 1'b1, 12'd40, 12'd9, 12'd0, 12'd0); // age 101
    endtask

    // Register extremes: zero gain, saturation, min above max, huge deadband
    task automatic test_register_extremes();
        apply_config('{16'd0, 16'd500, 16'd0, 12'd0, 12'd0, 32'd1000, 8'd255, 2'd3});
        send_track(32'h100, 1'b1, 1'b1, 1'b1, 12'd10, 12'd0, 12'd0, 12'd10);  // speed 0, running
        apply_config('{16'hFFFF, 16'hFFFF, 16'd0, 12'd0, 12'd0, 32'd0, 8'd0, 2'd1});
        send_track(32'h200, 1'b1, 1'b1, 1'b1, 12'd4095, 12'd1, 12'd0, 12'd0);
        send_track(32'h200, 1'b0, 1'b1, 1'b1, 12'd0, 12'd4095, 12'd4095, 12'd0); // age 0 ok
        send_track(32'h201, 1'b0, 1'b1, 1'b1, 12'd0, 12'd4095, 12'd4095, 12'd0); // age 1
        apply_config('{16'd1280, 16'd100, 16'hFFFF, 12'd0, 12'd0, 32'hFFFF_FFFF, 8'h5A, 2'd2});
        send_track(32'h300, 1'b0, 1'b1, 1'b1, 12'd4095, 12'd0, 12'd0, 12'd4095); // below min
        send_track(32'h1FF, 1'b0, 1'b1, 1'b1, 12'd2000, 12'd1, 12'd1, 12'd2000); // age all 1s
        apply_config('{16'hFFFF, 16'hFFFF, 16'hFFFF, 12'hFFF, 12'hFFF, 32'd100, 8'd1, 2'd0});
        send_track(32'h400, 1'b1, 1'b1, 1'b1, 12'd4095, 12'd0, 12'd0, 12'd4095); // in band
        apply_config('{16'hFFFF, 16'hFFFF, 16'hFFFF, 12'd0, 12'd0, 32'd100, 8'd2, 2'd0});
        send_track(32'h401, 1'b1, 1'b1, 1'b1, 12'd4095, 12'd0, 12'd0, 12'd4095); // equals min
    endtask

    // Output held off for a long stretch while requests keep coming
    task automatic test_output_backpressure();
        t_track_req r;
        apply_config('{RST_GAIN, RST_MAX_SPEED, RST_MIN_SPEED, RST_DEADBAND,
                       RST_HYSTERESIS, RST_TIMEOUT, RST_ACCEL, RST_INVERT});
        wall_ms = 32'h1000;
        tx_idle_pct = 0;
        hold_requests++;
        repeat (40) begin
            gen_tracking_req(r);
            send_request(r);
        end
        drain_commands();
        tx_idle_pct = 13;
    endtask

    // Random tracking traffic over several register settings
    task automatic test_random_tracking();
        t_track_req r;
        t_cfg       c;
        for (int phase = 0; phase < 8; phase++) begin
            case (phase)
                0: c = '{RST_GAIN, RST_MAX_SPEED, RST_MIN_SPEED, RST_DEADBAND,
                         RST_HYSTERESIS, RST_TIMEOUT, RST_ACCEL, RST_INVERT};
                1: c = '{16'hFFFF, 16'hFFFF, 16'd0, 12'd0, 12'd0, 32'hFFFF_FFFF, 8'hFF, 2'd3};
                2: c = '{16'd0, 16'd0, 16'd0, 12'd0, 12'd0, 32'd0, 8'd0, 2'd0};
                3: c = '{16'hFFFF, 16'hFFFF, 16'hFFFF, 12'hFFF, 12'hFFF, 32'd50, 8'd7, 2'd1};
                default: c = random_config();
            endcase
            apply_config(c);
            // one phase runs with no idling on either side
            tx_idle_pct = (phase == 4) ? 0 : 13;
            rx_idle_pct = (phase == 4) ? 0 : 13;
            repeat (90) begin
                gen_tracking_req(r);
                send_request(r);
            end
        end
        tx_idle_pct = 13;
        rx_idle_pct = 13;
    endtask

    initial begin
        i_rst_n        = 1'b0;
        i_cfg_valid    = 1'b0;
        i_cfg_index    = '0;
        i_cfg_data     = '0;
        i_valid        = 1'b0;
        i_now_ms       = '0;
        i_laser_fresh  = 1'b0;
        i_target_fresh = 1'b0;
        i_both_valid   = 1'b0;
        i_target_px_x  = '0;
        i_target_px_y  = '0;
        i_laser_px_x   = '0;
        i_laser_px_y   = '0;
        i_stop_request = 1'b0;
        shadow_cfg     = '{RST_GAIN, RST_MAX_SPEED, RST_MIN_SPEED, RST_DEADBAND,
                           RST_HYSTERESIS, RST_TIMEOUT, RST_ACCEL, RST_INVERT};
        heartbeat      = 32'd0;
        axis_stopped   = 2'b11;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_directed_defaults();
        test_register_extremes();
        test_output_backpressure();
        test_random_tracking();

        drain_commands();
        repeat (6) @(posedge i_clk);
        if (error_count == 0)
            $display("tb_two_axis_deadband_speed_tracker_top passed");
        else
            $display("tb_two_axis_deadband_speed_tracker_top failed");
        $finish;
    end

    // Watchdog
    initial begin
        #5_000_000;
        $display("tb_two_axis_deadband_speed_tracker_top failed");
        $finish;
    end

endmodule
